>>> design/q3k_pkg.sv
// ----------------------------------------------------------------------------
// q3k_pkg: shared types and constants for the 3-bit K-quant block unpacker
// Block layout, emit command type and the half-by-scale product function.
// ----------------------------------------------------------------------------
package q3k_pkg;

    localparam int WORDS_PER_BLOCK = 55;
    localparam int HMASK_BASE      = 0;
    localparam int QS_BASE         = 16;
    localparam int SCALES_BASE     = 48;
    localparam int D_WORD          = 54;
    localparam int GROUPS          = 64;
    localparam int CMD_DEPTH       = 2;

    // Command from the loader to the emitter: which bank holds a full block.
    typedef struct packed {
        logic bank;
    } cmd_t;

    // Exact float32 bits of half h times signed 6-bit s.
    function automatic logic [31:0] scale_times_d(input logic [15:0] h,
                                                  input logic signed [5:0] s);
        logic        hs;
        logic [4:0]  he;
        logic [9:0]  hm;
        logic        ss;
        logic [5:0]  sa;
        logic [10:0] sig;
        logic [16:0] prod;
        logic [4:0]  lz;
        logic [16:0] norm;
        logic [8:0]  ex;
        logic [31:0] r;
        hs   = h[15];
        he   = h[14:10];
        hm   = h[9:0];
        ss   = s[5];
        sa   = ss ? 6'(-s) : 6'(s);
        sig  = (he == 5'd0) ? {1'b0, hm} : {1'b1, hm};
        prod = 17'(sig) * 17'(sa);
        lz   = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (prod[i])
                lz = 5'(16 - i);
        end
        norm = prod << lz;
        // Value = prod * 2^(e-25) with e at least 1; top bit position 16-lz.
        ex   = 9'((he == 5'd0) ? 1 : he) + 9'd118 - 9'(lz);
        r    = {hs ^ ss, ex[7:0], norm[15:0], 7'd0};
        if (he == 5'h1F)
        begin
            if (hm != 10'd0)
                r = {hs, 31'h7FC00000 >> 0} | {9'd0, hm, 13'd0};
            else if (sa == 6'd0)
                r = 32'h7FC00000;
            else
                r = {hs ^ ss, 31'h7F800000};
        end
        else if (prod == 17'd0)
            r = {hs ^ ss, 31'd0};
        return r;
    endfunction

endpackage

>>> design/q3k_block_unpack_unit.sv
// ----------------------------------------------------------------------------
// q3k_block_unpack_unit: 3-bit K-quant block unpacker, top level
// Loads 55-word blocks and emits 64 decoded quant groups per block.
// ----------------------------------------------------------------------------
// Input: write one 16-bit word per beat with push while full is low; 55
// words form a block (mask, quants, scales, then the half scale d).
// Output: while empty is low the next group is on the result ports; pop
// takes it. Groups come out in ascending word_index, last_of_block on 63.
// Two block banks let the next block load while the previous drains; full
// rises once a loaded block waits for the emitter and stays high until the
// emitter takes it, so the input stalls for most of each block drain.
// Input takes one word per cycle while full is low. Each group is gathered
// by the emitter with one memory read per cycle from the single read port,
// the final read's data waiting for a free output register: groups below
// 16 take nine reads (quants, high bits, scales, d) and carry a scale, other
// groups only the quant and high-bit reads and no scale.
// A stalled pop holds the output register and the emitter.
// Reset clears counters and queues; block memory is not cleared.
// ----------------------------------------------------------------------------
module q3k_block_unpack_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] half_word,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  word_index,
    output logic signed [2:0] quant_lane0,
    output logic signed [2:0] quant_lane1,
    output logic signed [2:0] quant_lane2,
    output logic signed [2:0] quant_lane3,
    output logic        scale_valid,
    output logic signed [5:0] scale_signed,
    output logic [31:0] scale_product,
    output logic        last_of_block
);
    logic          wr_en;
    logic [6:0]    wr_addr;
    logic [15:0]   wr_data;
    logic          cmd_valid;
    logic          cmd_take;
    q3k_pkg::cmd_t cmd;

    q3k_loader u_loader (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .half_word(half_word), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    q3k_emitter u_emitter (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
        .empty(empty), .pop(pop), .word_index(word_index),
        .quant_lane0(quant_lane0), .quant_lane1(quant_lane1),
        .quant_lane2(quant_lane2), .quant_lane3(quant_lane3),
        .scale_valid(scale_valid), .scale_signed(scale_signed),
        .scale_product(scale_product), .last_of_block(last_of_block)
    );
endmodule

>>> design/q3k_loader.sv
// ----------------------------------------------------------------------------
// q3k_loader: input side of the unpacker
// Counts incoming words into one of two banks and queues a command per block.
// ----------------------------------------------------------------------------
module q3k_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] half_word,
    output logic        wr_en,
    output logic [6:0]  wr_addr,
    output logic [15:0] wr_data,
    output logic        cmd_valid,
    output q3k_pkg::cmd_t cmd,
    input  logic        cmd_take
);
    logic [5:0] count_reg, count_next;
    logic       bank_reg, bank_next;
    logic [1:0] fill_reg, fill_next;
    logic       acc;
    logic       done;

    // One bank drains while the other loads; full rises while a loaded block
    // still waits for the emitter, as the other bank may still be draining.
    assign full    = (fill_reg == 2'(q3k_pkg::CMD_DEPTH - 1));
    assign acc     = push && !full;
    assign done    = acc && (count_reg == 6'(q3k_pkg::WORDS_PER_BLOCK - 1));
    assign wr_en   = acc;
    assign wr_addr = {bank_reg, count_reg};
    assign wr_data = half_word;

    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        fill_next  = fill_reg;
        if (acc)
            count_next = done ? 6'd0 : count_reg + 6'd1;
        if (done)
            bank_next = ~bank_reg;
        fill_next = fill_reg + 2'(done) - 2'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 6'd0;
            bank_reg  <= 1'b0;
            fill_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
            fill_reg  <= fill_next;
        end
    end

    // The emitter always drains the older bank first.
    logic rd_bank_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_bank_reg <= 1'b0;
        else if (cmd_take)
            rd_bank_reg <= ~rd_bank_reg;
    end
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd.bank  = rd_bank_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
        else $error("command taken with none queued");
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
        else $error("write while both banks busy");
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 2'd2)
        else $error("bank fill overflow");
endmodule

>>> design/q3k_emitter.sv
// ----------------------------------------------------------------------------
// q3k_emitter: output side of the unpacker
// Holds the block banks and reads words per group into the result register.
// ----------------------------------------------------------------------------
module q3k_emitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [6:0]  wr_addr,
    input  logic [15:0] wr_data,
    input  logic        cmd_valid,
    input  q3k_pkg::cmd_t cmd,
    output logic        cmd_take,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  word_index,
    output logic signed [2:0] quant_lane0,
    output logic signed [2:0] quant_lane1,
    output logic signed [2:0] quant_lane2,
    output logic signed [2:0] quant_lane3,
    output logic        scale_valid,
    output logic signed [5:0] scale_signed,
    output logic [31:0] scale_product,
    output logic        last_of_block
);
    logic [15:0] mem [0:127];
    logic [15:0] rd_data_reg;

    // Per group reads ql lo/hi, qh lo/hi; below 16 also sc lo/hi, sh lo/hi, d.
    logic        busy_reg;
    logic [5:0]  k_reg;
    logic [3:0]  step_reg;
    logic [3:0]  last_step;
    logic [5:0]  rd_addr;
    logic        rd_valid_reg;
    logic [3:0]  rd_step_reg;
    logic [31:0] ql_reg, qh_reg, lo_reg, hi_reg;
    logic        out_full_reg;
    logic        slot_free;
    logic [5:0]  grp;
    logic [1:0]  l;
    logic [1:0]  ksc;

    assign grp       = {2'b00, k_reg[5], k_reg[2:0]};
    assign l         = k_reg[4:3];
    assign ksc       = k_reg[3:2];
    assign last_step = (k_reg < 6'd16) ? 4'd8 : 4'd3;
    assign slot_free = !out_full_reg || pop;

    always_comb
    begin
        case (step_reg)
            4'd0:    rd_addr = 6'(q3k_pkg::QS_BASE) + {grp[4:0], 1'b0};
            4'd1:    rd_addr = 6'(q3k_pkg::QS_BASE) + {grp[4:0], 1'b0} + 6'd1;
            4'd2:    rd_addr = {2'b00, grp[2:0], 1'b0};
            4'd3:    rd_addr = {2'b00, grp[2:0], 1'b1};
            4'd4:    rd_addr = 6'(q3k_pkg::SCALES_BASE) + {4'd0, ksc[0], 1'b0};
            4'd5:    rd_addr = 6'(q3k_pkg::SCALES_BASE) + {4'd0, ksc[0], 1'b1};
            4'd6:    rd_addr = 6'(q3k_pkg::SCALES_BASE + 4);
            4'd7:    rd_addr = 6'(q3k_pkg::SCALES_BASE + 5);
            default: rd_addr = 6'(q3k_pkg::D_WORD);
        endcase
    end

    logic bank_reg;
    logic issue;
    // The final read of a group is issued once; its data then waits for a slot.
    assign issue    = busy_reg && !(rd_step_reg == last_step && rd_valid_reg);
    assign cmd_take = !busy_reg && cmd_valid && !out_full_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[{bank_reg, rd_addr}];
    end

    // Sequencer: one read per cycle, the final read's data completes a beat.
    logic finish;
    assign finish = rd_valid_reg && rd_step_reg == last_step && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            k_reg        <= 6'd0;
            step_reg     <= 4'd0;
            rd_valid_reg <= 1'b0;
            rd_step_reg  <= 4'd0;
            bank_reg     <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                out_full_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            if (cmd_take)
            begin
                busy_reg <= 1'b1;
                bank_reg <= cmd.bank;
                k_reg    <= 6'd0;
                step_reg <= 4'd0;
            end
            else if (busy_reg)
            begin
                if (finish)
                begin
                    out_full_reg <= 1'b1;
                    step_reg     <= 4'd0;
                    k_reg        <= k_reg + 6'd1;
                    if (k_reg == 6'(q3k_pkg::GROUPS - 1))
                        busy_reg <= 1'b0;
                end
                else if (issue)
                begin
                    rd_valid_reg <= 1'b1;
                    rd_step_reg  <= step_reg;
                    if (step_reg != last_step)
                        step_reg <= step_reg + 4'd1;
                end
                else
                begin
                    rd_valid_reg <= rd_valid_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            case (rd_step_reg)
                4'd0:    ql_reg[15:0]  <= rd_data_reg;
                4'd1:    ql_reg[31:16] <= rd_data_reg;
                4'd2:    qh_reg[15:0]  <= rd_data_reg;
                4'd3:    qh_reg[31:16] <= rd_data_reg;
                4'd4:    lo_reg[15:0]  <= rd_data_reg;
                4'd5:    lo_reg[31:16] <= rd_data_reg;
                4'd6:    hi_reg[15:0]  <= rd_data_reg;
                4'd7:    hi_reg[31:16] <= rd_data_reg;
                default: ;
            endcase
        end
    end

    // Result assembly from the gathered words; the last read arrives directly.
    logic [31:0] qh_w;
    logic [31:0] hi_w;
    logic [4:0]  hshift;
    logic [2:0]  q [4];
    logic [5:0]  v;
    logic signed [5:0] s;
    always_comb
    begin
        qh_w   = (last_step == 4'd3) ? {rd_data_reg, qh_reg[15:0]} : qh_reg;
        hi_w   = {hi_reg[31:16], hi_reg[15:0]};
        hshift = {grp[4:3], 2'b00} + 5'(l);
        for (int j = 0; j < 4; j++)
        begin
            q[j][1:0] = 2'(ql_reg >> (8 * j + 2 * l));
            q[j][2]   = qh_w[8 * j + hshift];
        end
        v = {2'(hi_w >> (8 * k_reg[1:0] + 2 * ksc)),
             4'(lo_reg >> (8 * k_reg[1:0] + 4 * ksc[1]))};
        s = signed'(v ^ 6'h20);
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            word_index    <= k_reg;
            quant_lane0   <= signed'(q[0] ^ 3'd4);
            quant_lane1   <= signed'(q[1] ^ 3'd4);
            quant_lane2   <= signed'(q[2] ^ 3'd4);
            quant_lane3   <= signed'(q[3] ^ 3'd4);
            scale_valid   <= (last_step == 4'd8);
            scale_signed  <= (last_step == 4'd8) ? s : 6'sd0;
            scale_product <= (last_step == 4'd8) ?
                             q3k_pkg::scale_times_d(rd_data_reg, s) : 32'd0;
            last_of_block <= (k_reg == 6'(q3k_pkg::GROUPS - 1));
        end
    end

    assign empty = !out_full_reg;

    assert property (@(posedge clk) disable iff (!rst_n) finish |-> busy_reg)
        else $error("beat built while idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !pop) |=> (out_full_reg && $stable(word_index)))
        else $error("waiting beat lost");
    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> !busy_reg)
        else $error("block taken while busy");
endmodule
